FILE: rtl/duration_text_parser_unit_macros.svh
`ifndef DURATION_TEXT_PARSER_UNIT_MACROS_SVH
`define DURATION_TEXT_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dtp_pkg.sv
package dtp_pkg;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  typedef logic [2:0] unit_t;
  localparam unit_t U_NONE = 3'd0;
  localparam unit_t U_SEC  = 3'd1;
  localparam unit_t U_MIN  = 3'd2;
  localparam unit_t U_HOUR = 3'd3;
  localparam unit_t U_DAY  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D_UP  = 8'h44;
  localparam logic [7:0] CH_H_UP  = 8'h48;
  localparam logic [7:0] CH_M_UP  = 8'h4D;
  localparam logic [7:0] CH_S_UP  = 8'h53;
  localparam logic [7:0] CH_D_LO  = 8'h64;
  localparam logic [7:0] CH_H_LO  = 8'h68;
  localparam logic [7:0] CH_M_LO  = 8'h6D;
  localparam logic [7:0] CH_S_LO  = 8'h73;

  typedef struct packed {
    logic add;
    logic fin;
    logic ok;
  } ev_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic unit_t unit_of(input logic [7:0] c);
    unit_t u;
    unique case (c)
      CH_D_LO, CH_D_UP: u = U_DAY;
      CH_H_LO, CH_H_UP: u = U_HOUR;
      CH_M_LO, CH_M_UP: u = U_MIN;
      CH_S_LO, CH_S_UP: u = U_SEC;
      default:          u = U_NONE;
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/dtp_scan.sv
module dtp_scan import dtp_pkg::*; #(
  parameter int TOTAL_WIDTH = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             char_code,
  output logic                   ev_valid,
  input  logic                   ev_ready,
  output ev_ctl_t                ev_ctl,
  output logic [TOTAL_WIDTH-1:0] ev_prod
);

  localparam int W  = TOTAL_WIDTH;
  localparam int DW = TOTAL_WIDTH + 4;
  localparam int PW = TOTAL_WIDTH + 17;

  logic [1:0]    phase, phase_next;
  logic [W-1:0]  acc, acc_next;
  logic          seen, seen_next;

  logic [7:0]    dval_full;
  logic [3:0]    dval;
  unit_t         unit, unit_eff;
  logic [DW-1:0] dig_ext, acc_d;
  logic [PW-1:0] prod_ext, acc_p;
  logic          dig_ovf, prod_ovf, fresh;
  ev_ctl_t       ctl;

  assign in_ready  = !ev_valid || ev_ready;
  assign dval_full = char_code - CH_ZERO;
  assign dval      = dval_full[3:0];
  assign unit      = unit_of(char_code);
  assign unit_eff  = (unit == U_NONE) ? U_SEC : unit;

  assign acc_d   = {4'd0, acc};
  assign dig_ext = (acc_d << 3) + (acc_d << 1) + DW'(dval);
  assign dig_ovf = |dig_ext[DW-1:W];

  // constant multiply as shift-add: 86400, 3600, 60
  assign acc_p = {17'd0, acc};
  always_comb begin
    unique case (unit_eff)
      U_DAY:   prod_ext = (acc_p << 16) + (acc_p << 14) + (acc_p << 12)
                        + (acc_p << 8) + (acc_p << 7);
      U_HOUR:  prod_ext = (acc_p << 11) + (acc_p << 10) + (acc_p << 9) + (acc_p << 4);
      U_MIN:   prod_ext = (acc_p << 5) + (acc_p << 4) + (acc_p << 3) + (acc_p << 2);
      default: prod_ext = acc_p;
    endcase
  end
  assign prod_ovf = |prod_ext[PW-1:W];

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    seen_next  = seen;
    ctl        = '0;
    fresh      = 1'b1;
    if (phase == PH_DIGITS) begin
      if (is_digit(char_code)) begin
        fresh = 1'b0;
        if (dig_ovf) begin
          phase_next = PH_ERROR;
          acc_next   = '0;
        end else begin
          acc_next = dig_ext[W-1:0];
        end
      end else begin
        if (prod_ovf) begin
          phase_next = PH_ERROR;
        end else begin
          ctl.add    = 1'b1;
          acc_next   = '0;
          seen_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        // no unit letter: byte is handled again below
        fresh = (unit == U_NONE);
      end
    end
    if (fresh) begin
      if (char_code == CH_NUL) begin
        ctl.fin    = 1'b1;
        ctl.ok     = (phase_next == PH_IDLE) && seen_next;
        phase_next = PH_IDLE;
        acc_next   = '0;
        seen_next  = 1'b0;
      end else if (phase_next == PH_IDLE) begin
        if (is_digit(char_code)) begin
          acc_next   = W'(dval);
          phase_next = PH_DIGITS;
        end else if (!is_blank(char_code)) begin
          phase_next = PH_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      acc      <= '0;
      seen     <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        phase <= phase_next;
        acc   <= acc_next;
        seen  <= seen_next;
      end
      if (in_ready) begin
        ev_valid <= in_valid && (ctl.add || ctl.fin);
        ev_ctl   <= ctl;
        ev_prod  <= prod_ext[W-1:0];
      end
    end
  end

endmodule

FILE: rtl/dtp_accum.sv
module dtp_accum import dtp_pkg::*; #(
  parameter int TOTAL_WIDTH = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ev_valid,
  output logic                   ev_ready,
  input  ev_ctl_t                ev_ctl,
  input  logic [TOTAL_WIDTH-1:0] ev_prod,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   status,
  output logic [TOTAL_WIDTH-1:0] seconds
);

  localparam int W = TOTAL_WIDTH;

  logic [W-1:0] total;
  logic         oflow;
  logic [W:0]   sum;
  logic         add_ovf, good, take;
  logic [W-1:0] fin_total;

  assign sum       = {1'b0, total} + {1'b0, ev_prod};
  assign add_ovf   = ev_ctl.add && sum[W];
  assign ev_ready  = !ev_ctl.fin || !out_valid || out_ready;
  assign take      = ev_valid && ev_ready;
  assign good      = ev_ctl.ok && !oflow && !add_ovf;
  assign fin_total = ev_ctl.add ? sum[W-1:0] : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
      oflow     <= 1'b0;
    end else begin
      if (take && ev_ctl.fin) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (ev_ctl.fin) begin
          status    <= !good;
          seconds   <= good ? fin_total : '0;
          total     <= '0;
          oflow     <= 1'b0;
        end else if (add_ovf) begin
          oflow <= 1'b1;
        end else if (ev_ctl.add) begin
          total <= sum[W-1:0];
        end
      end
    end
  end

endmodule

FILE: rtl/duration_text_parser_unit.sv
// Duration text parser: takes one text byte per transfer, one per cycle when
// the result side keeps up, and on the zero byte delivers a status bit and the
// total in seconds. A token closes in the scan stage, where its number is
// turned into seconds by a constant shift-add multiply; the running sum is
// added in the following stage: the terminator's event is registered by the
// scan stage, then the result by the accumulator stage. Input stalls only when
// a finished result is still waiting and another terminator arrives behind it.
`include "duration_text_parser_unit_macros.svh"

module duration_text_parser_unit import dtp_pkg::*; #(
  parameter int TOTAL_WIDTH = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             char_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   status,
  output logic [TOTAL_WIDTH-1:0] seconds
);

  logic                   ev_valid;
  logic                   ev_ready;
  ev_ctl_t                ev_ctl;
  logic [TOTAL_WIDTH-1:0] ev_prod;

  dtp_scan #(
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_code(char_code),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev_ctl   (ev_ctl),
    .ev_prod  (ev_prod)
  );

  dtp_accum #(
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev_ctl   (ev_ctl),
    .ev_prod  (ev_prod),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .seconds  (seconds)
  );

  `DTP_ASSERT_NOW(a_stall_needs_event, !in_ready, ev_valid, "input stalled with no pending event")
  `DTP_ASSERT_NOW(a_error_zero_secs, out_valid && status, seconds == '0, "error result with nonzero seconds")
  `DTP_ASSERT_NEXT(a_nul_makes_end, in_valid && in_ready && char_code == CH_NUL, ev_valid && ev_ctl.fin, "terminator lost")

endmodule
